@@ src/tccw_pkg.sv @@
// shared types and constants for the text console cell writer
package tccw_pkg;

	localparam int CELL_W = 16;
	localparam int ADDR_W = 11;
	localparam int POS_W  = 11;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		CMD_CHAR,
		CMD_NEWLINE,
		CMD_CLEAR,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [CELL_W-1:0]  cell_val;
		logic [ADDR_W-1:0]  addr;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

@@ src/text_console_cell_writer_unit.sv @@
// top level of the text console cell writer
// A request transaction is taken at a rising edge with start high and busy low.
// Fields req_type, char_code, fg_color, bg_color and cell_index go with start.
// Each request gives one result: done is high for exactly one cycle with
// cursor_pos and cell_data, and the receiver cannot hold it off.
// Requests pass through a two-entry queue to the back end, which owns the
// cell memory (one write and one registered read port) and the cursor.
// A plain character, newline or out-of-range read gives done straight from
// the idle state; a read waits for the registered read port; a clear sweeps
// every cell; a character or newline that scrolls the grid copies each row
// up and blanks the bottom row. The scroll and clear sweeps move one cell
// per cycle through the memory port. Plain characters and newlines without
// a scroll sustain one per cycle. busy is high while the queue is full and
// during the initial clearing pass after reset, in which the back end clears
// every cell of the memory; the cursor starts at cell 0.
module text_console_cell_writer_unit #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    char_code,
	input  logic [3:0]                    fg_color,
	input  logic [3:0]                    bg_color,
	input  logic [tccw_pkg::ADDR_W-1:0]   cell_index,
	output logic                          done,
	output logic [tccw_pkg::POS_W-1:0]    cursor_pos,
	output logic [tccw_pkg::CELL_W-1:0]   cell_data
);

	logic                 push;
	logic                 pop;
	logic                 init_busy;
	tccw_pkg::cmd_t       push_cmd;
	tccw_pkg::cmd_t       head;
	tccw_pkg::q_status_t  q_status;

	assign busy = q_status.full || init_busy;

	tccw_front #(
		.NCELLS (COLS * ROWS)
	) u_front (
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.cell_index (cell_index),
		.push       (push),
		.cmd        (push_cmd)
	);

	tccw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	tccw_back #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.init_busy  (init_busy),
		.done       (done),
		.cursor_pos (cursor_pos),
		.cell_data  (cell_data)
	);

endmodule

@@ src/tccw_front.sv @@
// front end: takes requests and turns them into queued commands
module tccw_front #(
	parameter int NCELLS = 2000
) (
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               req_type,
	input  logic [7:0]               char_code,
	input  logic [3:0]               fg_color,
	input  logic [3:0]               bg_color,
	input  logic [tccw_pkg::ADDR_W-1:0] cell_index,
	output logic                     push,
	output tccw_pkg::cmd_t           cmd
);

	logic in_range;

	assign push     = start && !busy;
	assign in_range = 32'(cell_index) < NCELLS;

	always_comb begin
		cmd.cell_val = {bg_color, fg_color, char_code};
		cmd.addr     = cell_index;
		unique case (req_type)
			tccw_pkg::REQ_WRITE: begin
				cmd.kind = (char_code == tccw_pkg::NEWLINE_CODE) ?
					tccw_pkg::CMD_NEWLINE : tccw_pkg::CMD_CHAR;
			end
			tccw_pkg::REQ_CLEAR: begin
				cmd.kind = tccw_pkg::CMD_CLEAR;
			end
			tccw_pkg::REQ_READ: begin
				cmd.kind = in_range ? tccw_pkg::CMD_READ : tccw_pkg::CMD_NOP;
			end
			default: begin
				cmd.kind = tccw_pkg::CMD_NOP;
			end
		endcase
	end

endmodule

@@ src/tccw_queue.sv @@
// short command queue between front and back end
module tccw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tccw_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output tccw_pkg::cmd_t      head,
	output tccw_pkg::q_status_t status
);

	tccw_pkg::cmd_t               entry_q [tccw_pkg::QDEPTH];
	logic [tccw_pkg::QPW-1:0]     wr_ptr_q;
	logic [tccw_pkg::QPW-1:0]     rd_ptr_q;
	logic [tccw_pkg::QCW-1:0]     count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == tccw_pkg::QCW'(tccw_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/tccw_back.sv @@
// back end: cell memory, cursor, scroll and clear sweeps, result register
module tccw_back #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tccw_pkg::cmd_t               head,
	input  tccw_pkg::q_status_t          q_status,
	output logic                         pop,
	output logic                         init_busy,
	output logic                         done,
	output logic [tccw_pkg::POS_W-1:0]   cursor_pos,
	output logic [tccw_pkg::CELL_W-1:0]  cell_data
);

	localparam int NCELLS    = COLS * ROWS;
	localparam int AW        = $clog2(NCELLS);
	localparam int AWX       = AW + 1;
	localparam int CW        = $clog2(COLS);
	localparam int RW        = $clog2(ROWS);
	localparam int LAST      = NCELLS - 1;
	localparam int COPY_LAST = NCELLS - COLS - 1;
	localparam int BOT_ROW   = NCELLS - COLS;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_COPY,
		ST_BLANK
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                sweep_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [AW-1:0]                pos_q;
	logic                         cp_v_q;
	logic [AW-1:0]                cp_dst_q;
	logic                         done_q;
	logic [tccw_pkg::POS_W-1:0]   cursor_pos_q;
	logic [tccw_pkg::CELL_W-1:0]  cell_data_q;

	logic [tccw_pkg::CELL_W-1:0]  mem [NCELLS];
	logic [tccw_pkg::CELL_W-1:0]  rdata_q;

	logic                         mem_we;
	logic [AW-1:0]                mem_wa;
	logic [tccw_pkg::CELL_W-1:0]  mem_wd;
	logic [AW-1:0]                mem_ra;

	logic                         wrap;
	logic                         scroll;
	logic [AWX-1:0]               pos_inc;
	logic [CW-1:0]                col_n;
	logic [RW-1:0]                row_n;
	logic [AW-1:0]                pos_n;

	assign init_busy  = (state_q == ST_INIT);
	assign done       = done_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_data  = cell_data_q;

	// cursor step for a character or newline
	always_comb begin
		if (head.kind == tccw_pkg::CMD_NEWLINE) begin
			wrap    = 1'b1;
			pos_inc = AWX'(pos_q) - AWX'(col_q) + AWX'(COLS);
		end else begin
			wrap    = (col_q == CW'(COLS - 1));
			pos_inc = AWX'(pos_q) + 1'b1;
		end
		col_n  = wrap ? '0 : col_q + 1'b1;
		scroll = wrap && (row_q == RW'(ROWS - 1));
		row_n  = scroll ? row_q : row_q + RW'(wrap);
		pos_n  = scroll ? AW'(BOT_ROW) : AW'(pos_inc);
	end

	always_comb begin
		pop    = 1'b0;
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = head.cell_val;
		mem_ra = AW'(head.addr);
		unique case (state_q) inside
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
				mem_wd = '0;
			end
			ST_IDLE: begin
				pop    = !q_status.empty;
				mem_we = pop && (head.kind == tccw_pkg::CMD_CHAR);
			end
			ST_COPY: begin
				mem_ra = sweep_q + AW'(COLS);
				mem_we = cp_v_q;
				mem_wa = cp_dst_q;
				mem_wd = rdata_q;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
				mem_wa = cp_v_q ? cp_dst_q : sweep_q;
				mem_wd = cp_v_q ? rdata_q : '0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COPY) begin
			cp_dst_q <= sweep_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_q      <= '0;
			col_q        <= '0;
			row_q        <= '0;
			pos_q        <= '0;
			cp_v_q       <= 1'b0;
			done_q       <= 1'b0;
			cursor_pos_q <= '0;
			cell_data_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					if (sweep_q == AW'(LAST)) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						unique case (head.kind) inside
							tccw_pkg::CMD_CHAR, tccw_pkg::CMD_NEWLINE: begin
								col_q <= col_n;
								row_q <= row_n;
								pos_q <= pos_n;
								if (scroll) begin
									sweep_q <= '0;
									state_q <= ST_COPY;
								end else begin
									done_q       <= 1'b1;
									cursor_pos_q <= tccw_pkg::POS_W'(pos_n);
									cell_data_q  <= '0;
								end
							end
							tccw_pkg::CMD_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								pos_q   <= '0;
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							tccw_pkg::CMD_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								done_q       <= 1'b1;
								cursor_pos_q <= tccw_pkg::POS_W'(pos_q);
								cell_data_q  <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					done_q       <= 1'b1;
					cursor_pos_q <= tccw_pkg::POS_W'(pos_q);
					cell_data_q  <= rdata_q;
					state_q      <= ST_IDLE;
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(LAST)) begin
						done_q       <= 1'b1;
						cursor_pos_q <= '0;
						cell_data_q  <= '0;
						state_q      <= ST_IDLE;
					end
				end
				ST_COPY: begin
					cp_v_q  <= 1'b1;
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(COPY_LAST)) begin
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					if (cp_v_q) begin
						cp_v_q <= 1'b0;
					end else if (sweep_q == AW'(LAST)) begin
						done_q       <= 1'b1;
						cursor_pos_q <= tccw_pkg::POS_W'(pos_q);
						cell_data_q  <= '0;
						state_q      <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !done_q)
		else $error("result during initial clearing pass");

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= LAST)
		else $error("cursor outside the grid");

	a_pos_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) == 32'(row_q) * COLS + 32'(col_q))
		else $error("cursor position disagrees with row and column");

	a_copy_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_q |-> (state_q == ST_COPY || state_q == ST_BLANK))
		else $error("pending row copy outside a scroll");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE) && !q_status.empty)
		else $error("command taken from an empty queue");

endmodule
